// ===== design/itoa_pkg.sv =====
// Shared types, codes and constants of the integer to ASCII converter.
package itoa_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 8;
   localparam int BIN_W    = 32;
   localparam int BCD_DIGS = 10;
   localparam int BCD_W    = 4 * BCD_DIGS;
   localparam int ITER_W   = 5;
   localparam int NDIG_W   = 5;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(BIN_W - 1);

   // format selector codes
   localparam logic [OP_W-1:0] OP_SDEC      = 3'd0;
   localparam logic [OP_W-1:0] OP_UDEC      = 3'd1;
   localparam logic [OP_W-1:0] OP_HEX_LOWER = 3'd2;
   localparam logic [OP_W-1:0] OP_HEX_UPPER = 3'd3;
   localparam logic [OP_W-1:0] OP_POINTER   = 3'd4;

   localparam logic [CHAR_W-1:0]   CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [2*CHAR_W-1:0] PTR_PREFIX = 16'h3078; // "0x"

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CONV   = 5'b00010,
      ST_SKIP   = 5'b00100,
      ST_PREFIX = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   // one hex or decimal digit to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dig, input logic upper);
      logic [CHAR_W-1:0] base;
      if (dig < 4'd10) begin
         base = 8'h30;
         return base + {4'h0, dig};
      end else begin
         base = upper ? 8'h41 : 8'h61;
         return base + {4'h0, dig} - 8'd10;
      end
   endfunction

endpackage

// ===== design/itoa_channels.sv =====
// Valid/ready channel interfaces for requests and response characters.
interface itoa_req_if;
   logic                            valid;
   logic                            ready;
   logic [itoa_pkg::OP_W-1:0]       op;
   logic [itoa_pkg::VALUE_W-1:0]    value;
   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface itoa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [itoa_pkg::CHAR_W-1:0]     character;
   logic                            last;
   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/itoa_dabble_step.sv =====
// One shift-and-add-3 step of the binary to BCD conversion.
module itoa_dabble_step (
   input  logic [itoa_pkg::BCD_W-1:0] bcd_cur,
   input  logic                       shift_bit,
   output logic [itoa_pkg::BCD_W-1:0] bcd_next
);

   logic [itoa_pkg::BCD_W-1:0] adj;

   always_comb begin
      for (int d = 0; d < itoa_pkg::BCD_DIGS; d++) begin
         adj[4*d +: 4] = (bcd_cur[4*d +: 4] >= 4'd5) ? bcd_cur[4*d +: 4] + 4'd3
                                                      : bcd_cur[4*d +: 4];
      end
   end

   assign bcd_next = {adj[itoa_pkg::BCD_W-2:0], shift_bit};

endmodule

// ===== design/integer_to_ascii_converter.sv =====
// Integer to ASCII converter: top level with sequencer and output register.
//
// Each request transaction carries a format code and a 64-bit value; the block
// answers with the ASCII text as a run of response transactions, most
// significant character first, no leading zeros, last set on the final one.
// Formats: signed decimal, unsigned decimal, lowercase hex, uppercase hex (all
// of the low 32 bits) and pointer ("0x" plus lowercase hex of all 64 bits).
// Format codes 5..7 are accepted and produce no characters. Decimal values go
// through a shared shift-and-add-3 step, one bit per cycle. Leading zero
// digits are then dropped one per cycle (up to 9 for decimal, 7 or 15 for
// hex), and one character leaves per cycle while the consumer keeps ready
// high. Every dropped zero saves one character, and a response stall holds
// up prefix and digit output. The request side is ready only while idle;
// the last character may still sit in the output register while the next
// request is taken.
module integer_to_ascii_converter (
   input  logic         clock,
   input  logic         reset,
   itoa_req_if.sink     req_channel,
   itoa_rsp_if.source   rsp_channel
);

   itoa_pkg::state_type state_ff, state_in;

   logic [itoa_pkg::BIN_W-1:0]     src_ff, src_in;       // binary being shifted out
   logic [itoa_pkg::BCD_W-1:0]     bcd_ff, bcd_in;       // BCD accumulator
   logic [itoa_pkg::BCD_W-1:0]     bcd_step;
   logic [itoa_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [itoa_pkg::VALUE_W-1:0]   work_ff, work_in;     // digits, top nibble first
   logic [itoa_pkg::NDIG_W-1:0]    ndig_ff, ndig_in;     // digits left to send
   logic [2*itoa_pkg::CHAR_W-1:0]  pre_ff, pre_in;       // prefix characters
   logic [1:0]                     pre_cnt_ff, pre_cnt_in;
   logic                           upper_ff, upper_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           load;   // output register can take a character
   logic [itoa_pkg::BIN_W-1:0]     low;

   assign load = !rsp_valid_ff || rsp_channel.ready;
   assign low  = req_channel.value[itoa_pkg::BIN_W-1:0];

   // shared conversion step
   itoa_dabble_step u_step (
      .bcd_cur   (bcd_ff),
      .shift_bit (src_ff[itoa_pkg::BIN_W-1]),
      .bcd_next  (bcd_step)
   );

   assign req_channel.ready     = (state_ff == itoa_pkg::ST_IDLE);
   assign rsp_channel.valid     = rsp_valid_ff;
   assign rsp_channel.character = rsp_char_ff;
   assign rsp_channel.last      = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      bcd_in       = bcd_ff;
      iter_in      = iter_ff;
      work_in      = work_ff;
      ndig_in      = ndig_ff;
      pre_in       = pre_ff;
      pre_cnt_in   = pre_cnt_ff;
      upper_in     = upper_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (req_channel.valid) begin
               upper_in   = (req_channel.op == itoa_pkg::OP_HEX_UPPER);
               pre_in     = '0;
               pre_cnt_in = 2'd0;
               iter_in    = '0;
               bcd_in     = '0;
               case (req_channel.op)
                  itoa_pkg::OP_SDEC: begin
                     if (low[itoa_pkg::BIN_W-1]) begin
                        src_in     = ~low + 32'd1;
                        pre_in     = {itoa_pkg::CHAR_MINUS, 8'h00};
                        pre_cnt_in = 2'd1;
                     end else begin
                        src_in = low;
                     end
                     state_in = itoa_pkg::ST_CONV;
                  end
                  itoa_pkg::OP_UDEC: begin
                     src_in   = low;
                     state_in = itoa_pkg::ST_CONV;
                  end
                  itoa_pkg::OP_HEX_LOWER, itoa_pkg::OP_HEX_UPPER: begin
                     work_in  = {low, 32'h0};
                     ndig_in  = 5'd8;
                     state_in = itoa_pkg::ST_SKIP;
                  end
                  itoa_pkg::OP_POINTER: begin
                     work_in    = req_channel.value;
                     ndig_in    = 5'd16;
                     pre_in     = itoa_pkg::PTR_PREFIX;
                     pre_cnt_in = 2'd2;
                     state_in   = itoa_pkg::ST_SKIP;
                  end
                  default: begin
                     // unused codes: taken, no characters
                     state_in = itoa_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         itoa_pkg::ST_CONV: begin
            bcd_in  = bcd_step;
            src_in  = {src_ff[itoa_pkg::BIN_W-2:0], 1'b0};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == itoa_pkg::ITER_LAST) begin
               // align ten BCD digits to the top of the digit register
               work_in  = {bcd_step, 24'h0};
               ndig_in  = 5'd10;
               state_in = itoa_pkg::ST_SKIP;
            end
         end
         itoa_pkg::ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (work_ff[63:60] == 4'h0 && ndig_ff > 5'd1) begin
               work_in = {work_ff[59:0], 4'h0};
               ndig_in = ndig_ff - 5'd1;
            end else if (pre_cnt_ff != 2'd0) begin
               state_in = itoa_pkg::ST_PREFIX;
            end else begin
               state_in = itoa_pkg::ST_EMIT;
            end
         end
         itoa_pkg::ST_PREFIX: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = pre_ff[15:8];
               rsp_last_in  = 1'b0;
               pre_in       = {pre_ff[7:0], 8'h00};
               pre_cnt_in   = pre_cnt_ff - 2'd1;
               if (pre_cnt_ff == 2'd1) begin
                  state_in = itoa_pkg::ST_EMIT;
               end
            end
         end
         itoa_pkg::ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itoa_pkg::digit_char(work_ff[63:60], upper_ff);
               rsp_last_in  = (ndig_ff == 5'd1);
               work_in      = {work_ff[59:0], 4'h0};
               ndig_in      = ndig_ff - 5'd1;
               if (ndig_ff == 5'd1) begin
                  state_in = itoa_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         ndig_ff      <= '0;
         pre_cnt_ff   <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         ndig_ff      <= ndig_in;
         pre_cnt_ff   <= pre_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      bcd_ff      <= bcd_in;
      work_ff     <= work_in;
      pre_ff      <= pre_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // conversion moves on to skipping zeros after its last step
   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_CONV && iter_ff == itoa_pkg::ITER_LAST)
         |=> state_ff == itoa_pkg::ST_SKIP)
      else $error("conversion did not finish after last step");

   // the final digit closes the transaction run and returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_EMIT && load && ndig_ff == 5'd1)
         |=> (state_ff == itoa_pkg::ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("last digit not flagged or sequencer not idle");

   // at least one and at most 16 digits are pending while skipping or emitting
   a_emit_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_EMIT || state_ff == itoa_pkg::ST_SKIP)
         |-> (ndig_ff != 5'd0 && ndig_ff <= 5'd16))
      else $error("digit count out of range");

   // prefix characters are never flagged last
   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_PREFIX && load) |=> !rsp_last_ff)
      else $error("prefix character flagged last");

endmodule

// ===== tb/sv/integer_to_ascii_converter_test.sv =====
// Self-checking testbench for the integer to ASCII converter.
module integer_to_ascii_converter_test;

   // Watchdog: cycles in a row with no transaction on either channel.
   // The longest quiet stretch is a decimal conversion or a run of response
   // stalls, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 4000;
   // Cycles to keep watching after the last expected character.
   localparam int TAIL_CYCLES = 80;

   typedef struct packed {
      logic [itoa_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itoa_req_if req_if ();
   itoa_rsp_if rsp_if ();

   integer_to_ascii_converter uut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   // Characters predicted for accepted numbers, oldest first.
   text_char_type pending_chars[$];

   int failures      = 0;
   int chars_checked = 0;
   int quiet_cycles  = 0;
   int format_count[0:7];
   // When set, neither side inserts idle cycles.
   bit calm          = 1'b0;
   int rsp_stall_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor: the full text of one number, pushed onto pending_chars.
   // ------------------------------------------------------------------------
   function automatic void predict_text(input logic [itoa_pkg::OP_W-1:0] op,
                                        input logic [itoa_pkg::VALUE_W-1:0] value);
      string                       lower_table;
      string                       upper_table;
      logic [63:0]                 mag;
      logic [63:0]                 radix;
      logic [31:0]                 neg_low;
      bit                          upper;
      int                          idx;
      logic [itoa_pkg::CHAR_W-1:0] text[$];
      logic [itoa_pkg::CHAR_W-1:0] digs[$];
      text_char_type               item;
      lower_table = "0123456789abcdef";
      upper_table = "0123456789ABCDEF";
      mag   = {32'd0, value[31:0]};
      radix = 64'd10;
      upper = 1'b0;
      case (op)
         itoa_pkg::OP_SDEC: begin
            // negative: sign, then magnitude; the most negative value
            // wraps to itself and prints as 2147483648
            if (value[31]) begin
               text.push_back(itoa_pkg::CHAR_MINUS);
               neg_low = 32'd0 - value[31:0];
               mag = {32'd0, neg_low};
            end
         end
         itoa_pkg::OP_UDEC: ;
         itoa_pkg::OP_HEX_LOWER: radix = 64'd16;
         itoa_pkg::OP_HEX_UPPER: begin
            radix = 64'd16;
            upper = 1'b1;
         end
         itoa_pkg::OP_POINTER: begin
            text.push_back(itoa_pkg::PTR_PREFIX[15:8]);
            text.push_back(itoa_pkg::PTR_PREFIX[7:0]);
            mag   = value;
            radix = 64'd16;
         end
         default: return;  // unused selector: no characters
      endcase
      do begin
         idx = int'(mag % radix);
         digs.push_front(upper ? upper_table[idx] : lower_table[idx]);
         mag = mag / radix;
      end while (mag != 64'd0);
      text = {text, digs};
      foreach (text[k]) begin
         item.character = text[k];
         item.last      = (k == text.size() - 1);
         pending_chars.push_back(item);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor and checker, sampled at the rising edge. The request side is
   // handled first so that a number accepted at this edge is queued behind
   // all older text.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      text_char_type exp_char;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_text(req_if.op, req_if.value);
            format_count[req_if.op]++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
               $error("unexpected character transaction: character 0x%02h last %0b",
                      rsp_if.character, rsp_if.last);
               failures++;
            end else begin
               exp_char = pending_chars.pop_front();
               if (rsp_if.character !== exp_char.character) begin
                  $error("character: expected 0x%02h, actual 0x%02h",
                         exp_char.character, rsp_if.character);
                  failures++;
               end
               if (rsp_if.last !== exp_char.last) begin
                  $error("last: expected %0b, actual %0b",
                         exp_char.last, rsp_if.last);
                  failures++;
               end
            end
         end
         // watchdog on channel activity
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("integer_to_ascii_converter regression: fail");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Response ready: random stall bursts, none when calm.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_if.ready   <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= $urandom_range(1, 7) - 1;
      end else
         rsp_if.ready   <= 1'b1;
   end

   // ------------------------------------------------------------------------
   // Sender: drive one number at the falling edge and hold it until the
   // transaction completes. Valid stays high into the next call unless a
   // random gap drops it.
   // ------------------------------------------------------------------------
   task automatic send_number(input logic [itoa_pkg::OP_W-1:0] op,
                              input logic [itoa_pkg::VALUE_W-1:0] value);
      int gap;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every predicted character has been seen.
   // Starts at a falling edge so the monitor has queued the last number.
   task automatic drain_pending_text;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   // Value mix: full random, random bit length, tiny, decade boundaries,
   // and negative in the low word.
   function automatic logic [itoa_pkg::VALUE_W-1:0] random_value;
      logic [itoa_pkg::VALUE_W-1:0] v;
      logic [31:0]                  p;
      int                           k;
      case ($urandom_range(0, 4))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         2: v = {$urandom, 32'd0} | 64'($urandom_range(0, 99));
         3: begin
            k = $urandom_range(1, 9);
            p = 32'd1;
            repeat (k) p = p * 32'd10;
            v = {$urandom, p + 32'($urandom_range(0, 2)) - 32'd1};
         end
         default: v = {$urandom, $urandom | 32'h8000_0000};
      endcase
      return v;
   endfunction

   // Mostly the five formats; now and then an unused selector.
   function automatic logic [itoa_pkg::OP_W-1:0] random_op;
      int r;
      r = $urandom_range(0, 19);
      if (r < 18) return itoa_pkg::OP_W'(r % 5);
      return itoa_pkg::OP_W'(5 + $urandom_range(0, 2));
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes, every format, sign edge cases, zero, ignored upper
   // bits and the unused selectors.
   task automatic test_directed_cases;
      send_number(itoa_pkg::OP_SDEC,      64'd0);
      send_number(itoa_pkg::OP_SDEC,      64'h0000_0000_7FFF_FFFF);
      send_number(itoa_pkg::OP_SDEC,      64'h0000_0000_8000_0000);   // most negative
      send_number(itoa_pkg::OP_SDEC,      64'hFFFF_FFFF_FFFF_FFFF);   // -1
      send_number(itoa_pkg::OP_SDEC,      64'h1234_5678_0000_0009);   // upper bits ignored
      send_number(itoa_pkg::OP_UDEC,      64'd0);
      send_number(itoa_pkg::OP_UDEC,      64'h0000_0000_FFFF_FFFF);
      send_number(itoa_pkg::OP_UDEC,      64'hFFFF_FFFF_8000_0000);
      send_number(itoa_pkg::OP_UDEC,      64'h0000_0000_3B9A_CA00);   // 1000000000
      send_number(itoa_pkg::OP_HEX_LOWER, 64'd0);
      send_number(itoa_pkg::OP_HEX_LOWER, 64'hFFFF_FFFF_DEAD_BEEF);
      send_number(itoa_pkg::OP_HEX_LOWER, 64'h0000_0000_0000_000F);
      send_number(itoa_pkg::OP_HEX_UPPER, 64'd0);
      send_number(itoa_pkg::OP_HEX_UPPER, 64'h0000_0000_FFFF_FFFF);
      send_number(itoa_pkg::OP_HEX_UPPER, 64'hAAAA_5555_00AB_CDEF);
      send_number(itoa_pkg::OP_POINTER,   64'd0);                     // "0x0"
      send_number(itoa_pkg::OP_POINTER,   64'hFFFF_FFFF_FFFF_FFFF);   // longest text
      send_number(itoa_pkg::OP_POINTER,   64'h0000_0000_0000_0001);
      send_number(itoa_pkg::OP_POINTER,   64'h8000_0000_0000_0000);
      send_number(itoa_pkg::OP_POINTER,   64'h0123_4567_89AB_CDEF);
      send_number(3'd5,                   64'hFFFF_FFFF_FFFF_FFFF);
      send_number(3'd6,                   64'd0);
      send_number(3'd7,                   64'h5555_AAAA_5555_AAAA);
      send_number(itoa_pkg::OP_SDEC,      64'hFFFF_FFFF_8000_0001);
   endtask

   // Sender holds off until all pending text is out, then resumes.
   task automatic test_drain_pause;
      repeat (6) send_number(random_op(), random_value());
      drain_pending_text();
      repeat (6) send_number(random_op(), random_value());
      drain_pending_text();
   endtask

   // Random numbers with idling on both sides; ignored selectors do not count.
   task automatic test_random_numbers(input int count);
      int                        sent;
      logic [itoa_pkg::OP_W-1:0] op;
      sent = 0;
      while (sent < count) begin
         op = random_op();
         send_number(op, random_value());
         if (op <= itoa_pkg::OP_POINTER) sent++;
      end
   endtask

   // Closing stretch: no idling, back-to-back transactions.
   task automatic test_back_to_back(input int count);
      drain_pending_text();
      calm = 1'b1;
      test_random_numbers(count);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.op    = itoa_pkg::OP_SDEC;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      foreach (format_count[i]) format_count[i] = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_drain_pause();
      test_random_numbers(200);
      drain_pending_text();
      test_random_numbers(180);
      test_back_to_back(50);

      drain_pending_text();
      // give any stray characters a chance to show up
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (pending_chars.size() != 0) begin
         $error("%0d expected characters never arrived", pending_chars.size());
         failures++;
      end
      $display("covered: sdec %0d, udec %0d, hex lower %0d, hex upper %0d, pointer %0d",
               format_count[itoa_pkg::OP_SDEC], format_count[itoa_pkg::OP_UDEC],
               format_count[itoa_pkg::OP_HEX_LOWER], format_count[itoa_pkg::OP_HEX_UPPER],
               format_count[itoa_pkg::OP_POINTER]);
      $display("ignored selectors %0d, characters checked %0d, mismatches %0d",
               format_count[5] + format_count[6] + format_count[7], chars_checked,
               failures);
      if (failures == 0) begin
         $display("integer_to_ascii_converter regression: pass");
      end else begin
         $display("integer_to_ascii_converter regression: fail");
      end
      $finish;
   end

endmodule
